### sv/rgbga_pkg.sv
// ----------------------------------------------------------------------------
// rgbga_pkg
// Shared constants for the RGB565 glyph alpha blend core: coordinate width,
// clip and config port widths, register indexes, clip reset bound and opaque alpha.
// ----------------------------------------------------------------------------
package rgbga_pkg;

    // signed pixel coordinate width
    localparam int COORD_BITS = 12;

    // clip register widths
    localparam int CLIP_LO_BITS = 11;
    localparam int CLIP_HI_BITS = 12;

    // common signed width for the clip compares
    localparam int CMP_BITS = ((COORD_BITS > CLIP_HI_BITS) ? COORD_BITS : CLIP_HI_BITS) + 1;

    // configuration port widths
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRAW_COLOR  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_LEFT   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_TOP    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_RIGHT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_BOTTOM = 3'd4;

    // clip window reset bounds
    localparam logic [CLIP_HI_BITS-1:0] CLIP_HI_RESET = 12'd2048;

    // coverage value for a fully opaque glyph pixel
    localparam logic [7:0] COVERAGE_OPAQUE = 8'd255;

endpackage

### sv/rgbga_pixel_blend.sv
// ----------------------------------------------------------------------------
// rgbga_pixel_blend
// Combinational blend of the draw color onto a background RGB565 pixel,
// per channel d + (s - d) * a / 255 with truncation toward zero.
// ----------------------------------------------------------------------------
module rgbga_pixel_blend
(
    input  logic [15:0] draw_color,
    input  logic [15:0] background,
    input  logic [7:0]  coverage,
    output logic [15:0] pixel
);
    import rgbga_pkg::*;

    // one channel, up to 6 bits wide; the divide by 255 uses
    // (p + 1 + (p >> 8)) >> 8, exact for p below 65535
    function automatic logic [5:0] blend_chan(input logic [5:0] s,
                                              input logic [5:0] d,
                                              input logic [7:0] a);
        logic        neg;
        logic [5:0]  mag;
        logic [13:0] prod;
        logic [14:0] sum;
        logic [6:0]  quo;
        logic [6:0]  res;
        neg  = (s < d);
        mag  = neg ? (d - s) : (s - d);
        prod = mag * a;
        sum  = {1'b0, prod} + 15'd1 + {9'd0, prod[13:8]};
        quo  = sum[14:8];
        res  = neg ? ({1'b0, d} - quo) : ({1'b0, d} + quo);
        return res[5:0];
    endfunction

    logic [5:0] red_full;
    logic [5:0] green;
    logic [5:0] blue_full;

    // per channel blend
    assign red_full  = blend_chan({1'b0, draw_color[15:11]}, {1'b0, background[15:11]},
                                  coverage);
    assign green     = blend_chan(draw_color[10:5], background[10:5], coverage);
    assign blue_full = blend_chan({1'b0, draw_color[4:0]}, {1'b0, background[4:0]},
                                  coverage);

    // opaque coverage takes the draw color as it is
    always_comb
    begin
        if (coverage == COVERAGE_OPAQUE)
        begin
            pixel = draw_color;
        end
        else
        begin
            pixel = {red_full[4:0], green, blue_full[4:0]};
        end
    end

endmodule

### sv/rgb565_glyph_alpha_blend_core.sv
// ----------------------------------------------------------------------------
// rgb565_glyph_alpha_blend_core
// Clip test and coverage blend of a draw color onto RGB565 frame pixels.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock (pos_x, pos_y, coverage, background) and
// returns one result word per pixel (write_enable, pixel_out). Each pixel
// passes through the input register, then the result register, with the
// clip compares and the three channel multiplies between them. Sustained
// rate is one pixel per clock while out_ready stays high. Outside the clip
// window (left/top inclusive, right/bottom exclusive) write_enable is 0 and
// pixel_out is 0. Registers: 0 draw_color, 1 clip_left, 2 clip_top,
// 3 clip_right, 4 clip_bottom; other indexes are ignored. Write
// configuration only while no pixel is in flight.
module rgb565_glyph_alpha_blend_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rgbga_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rgbga_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // pixel input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [rgbga_pkg::COORD_BITS-1:0] pos_x,
    input  logic signed [rgbga_pkg::COORD_BITS-1:0] pos_y,
    input  logic [7:0]                            coverage,
    input  logic [15:0]                           background,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  write_enable,
    output logic [15:0]                           pixel_out
);
    import rgbga_pkg::*;

    // configuration registers
    logic [15:0]             draw_color_reg;
    logic [CLIP_LO_BITS-1:0] clip_left_reg;
    logic [CLIP_LO_BITS-1:0] clip_top_reg;
    logic [CLIP_HI_BITS-1:0] clip_right_reg;
    logic [CLIP_HI_BITS-1:0] clip_bottom_reg;

    // input stage
    logic                         s1_valid_reg;
    logic signed [COORD_BITS-1:0] s1_x_reg;
    logic signed [COORD_BITS-1:0] s1_y_reg;
    logic [7:0]                   s1_cov_reg;
    logic [15:0]                  s1_bg_reg;

    // result stage
    logic        out_valid_reg;
    logic        out_we_reg;
    logic [15:0] out_pix_reg;

    logic        s1_advance;
    logic        in_accept;
    logic        in_clip;
    logic [15:0] blend_pix;
    logic signed [CMP_BITS-1:0] x_ext;
    logic signed [CMP_BITS-1:0] y_ext;
    logic signed [CMP_BITS-1:0] left_ext;
    logic signed [CMP_BITS-1:0] top_ext;
    logic signed [CMP_BITS-1:0] right_ext;
    logic signed [CMP_BITS-1:0] bottom_ext;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_color_reg  <= '0;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= CLIP_HI_RESET;
            clip_bottom_reg <= CLIP_HI_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DRAW_COLOR:  draw_color_reg  <= cfg_data[15:0];
                REG_CLIP_LEFT:   clip_left_reg   <= cfg_data[CLIP_LO_BITS-1:0];
                REG_CLIP_TOP:    clip_top_reg    <= cfg_data[CLIP_LO_BITS-1:0];
                REG_CLIP_RIGHT:  clip_right_reg  <= cfg_data[CLIP_HI_BITS-1:0];
                REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data[CLIP_HI_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // pipeline handshake
    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_x_reg   <= pos_x;
            s1_y_reg   <= pos_y;
            s1_cov_reg <= coverage;
            s1_bg_reg  <= background;
        end
    end

    // clip window test in a common signed width
    assign x_ext      = CMP_BITS'(s1_x_reg);
    assign y_ext      = CMP_BITS'(s1_y_reg);
    assign left_ext   = signed'({{(CMP_BITS-CLIP_LO_BITS){1'b0}}, clip_left_reg});
    assign top_ext    = signed'({{(CMP_BITS-CLIP_LO_BITS){1'b0}}, clip_top_reg});
    assign right_ext  = signed'({{(CMP_BITS-CLIP_HI_BITS){1'b0}}, clip_right_reg});
    assign bottom_ext = signed'({{(CMP_BITS-CLIP_HI_BITS){1'b0}}, clip_bottom_reg});

    assign in_clip = (x_ext >= left_ext) && (x_ext < right_ext) &&
                     (y_ext >= top_ext) && (y_ext < bottom_ext);

    // channel blend
    rgbga_pixel_blend u_blend
    (
        .draw_color (draw_color_reg),
        .background (s1_bg_reg),
        .coverage   (s1_cov_reg),
        .pixel      (blend_pix)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_we_reg  <= in_clip;
            out_pix_reg <= in_clip ? blend_pix : 16'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = out_we_reg;
    assign pixel_out    = out_pix_reg;

`ifndef SYNTHESIS
    // clipped pixels carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |-> (pixel_out == 16'd0))
        else $error("clipped pixel with nonzero value");

    // a word in the input register moves on when the result side is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance) |=> out_valid)
        else $error("input stage word lost");

    // an empty input register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled while input stage empty");

    // a stalled result holds while the input stage keeps its word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && s1_valid_reg) |=> (s1_valid_reg && out_valid))
        else $error("input stage overrun under stall");
`endif

endmodule
